[src/lidar_frame_check_and_accept_macros.svh]
// Assertion macros for the checker file of the range-finder frame block.
// No dependencies; take in with `include before use.
`ifndef LIDAR_FRAME_CHECK_AND_ACCEPT_MACROS_SVH
`define LIDAR_FRAME_CHECK_AND_ACCEPT_MACROS_SVH

// Clocked assertion, switched off while the active-low reset is asserted.
`define LFCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define LFCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lfca_pkg.sv]
// Package for the range-finder frame checker: beat types, codes and constants.
// No dependencies; used by every module of the block.
package lfca_pkg;

    localparam int CNT_W = 32;

    localparam logic [7:0]  HDR_BYTE    = 8'h59;
    localparam logic [3:0]  LAST_POS    = 4'd8;
    localparam logic [3:0]  POS_IDLE    = 4'd9;
    localparam logic [15:0] DELTA_RESET = 16'd10;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FRAMING = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_DISAGREE = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_FRAMING  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       frame_start;
        logic       slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] distance;
        logic [15:0] strength;
        logic [7:0]  int_time;
        logic [31:0] total_errors;
        logic [31:0] header_errors;
        logic [31:0] checksum_errors;
        logic [31:0] framing_errors;
    } t_out_item;

    // Event from the frame assembler to the judge, already qualified by the step.
    typedef struct packed {
        logic            judge;
        logic            framing;
        logic            timeout;
        logic            slot;
        logic [7:0]      last;
        logic [7:0][7:0] bytes;
    } t_asm_evt;

endpackage

[src/lfca_assemble.sv]
// Frame assembler: tracks the byte position and holds the first eight frame bytes.
// Depends on lfca_pkg.
module lfca_assemble (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  lfca_pkg::t_in_item i_item,
    output lfca_pkg::t_asm_evt o_evt
);

    logic [3:0]      r_pos;
    logic [3:0]      n_pos;
    logic [7:0][7:0] r_bytes;
    logic [3:0]      pos;
    logic            wr;

    always_comb begin
        pos           = i_item.frame_start ? 4'd0 : r_pos;
        n_pos         = r_pos;
        wr            = 1'b0;
        o_evt.judge   = 1'b0;
        o_evt.framing = 1'b0;
        o_evt.timeout = 1'b0;
        o_evt.slot    = i_item.slot;
        o_evt.last    = i_item.data_byte;
        o_evt.bytes   = r_bytes;
        unique case (i_item.op)
            lfca_pkg::OP_BYTE: begin
                // a start byte always reopens the frame; a stray byte while idle is dropped
                if (pos < lfca_pkg::POS_IDLE) begin
                    if (pos == lfca_pkg::LAST_POS) begin
                        o_evt.judge = i_go;
                        n_pos       = lfca_pkg::POS_IDLE;
                    end else begin
                        wr    = 1'b1;
                        n_pos = pos + 4'd1;
                    end
                end else begin
                    n_pos = pos;
                end
            end
            lfca_pkg::OP_FRAMING: begin
                o_evt.framing = i_go;
                n_pos         = lfca_pkg::POS_IDLE;
            end
            lfca_pkg::OP_TIMEOUT: begin
                o_evt.timeout = i_go;
                n_pos         = lfca_pkg::POS_IDLE;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= lfca_pkg::POS_IDLE;
        end else if (i_go) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && wr) begin
            r_bytes[pos[2:0]] <= i_item.data_byte;
        end
    end

endmodule

[src/lfca_judge.sv]
// Frame judge: header and checksum checks, sample slots, averaging and error counters.
// Depends on lfca_pkg; fed by lfca_assemble.
module lfca_judge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  lfca_pkg::t_asm_evt  i_evt,
    output logic                o_push,
    output lfca_pkg::t_out_item o_res
);

    logic [15:0]       r_delta;
    logic [1:0][15:0]  r_slots;
    logic [1:0][15:0]  n_slots;
    logic [15:0]       r_dist;
    logic [15:0]       n_dist;
    logic [15:0]       r_str;
    logic [15:0]       n_str;
    logic [7:0]        r_int;
    logic [7:0]        n_int;
    lfca_pkg::t_cnt    r_tot;
    lfca_pkg::t_cnt    n_tot;
    lfca_pkg::t_cnt    r_hdr;
    lfca_pkg::t_cnt    n_hdr;
    lfca_pkg::t_cnt    r_cks;
    lfca_pkg::t_cnt    n_cks;
    lfca_pkg::t_cnt    r_frm;
    lfca_pkg::t_cnt    n_frm;

    logic        hdr_ok;
    logic        cks_ok;
    logic [7:0]  sum;
    logic [15:0] new_dist;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] diff;
    logic        close;
    logic [16:0] pair_sum;
    logic [2:0]  status;

    always_comb begin
        hdr_ok = (i_evt.bytes[0] == lfca_pkg::HDR_BYTE) &&
                 (i_evt.bytes[1] == lfca_pkg::HDR_BYTE);
        sum = 8'd0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + i_evt.bytes[i];
        end
        cks_ok   = (sum == i_evt.last);
        new_dist = {i_evt.bytes[3], i_evt.bytes[2]};
        // the new reading takes its slot, the other slot keeps its old value
        a        = i_evt.slot ? r_slots[0] : new_dist;
        b        = i_evt.slot ? new_dist : r_slots[1];
        diff     = (a >= b) ? (a - b) : (b - a);
        close    = (diff <= r_delta);
        pair_sum = {1'b0, a} + {1'b0, b};
    end

    always_comb begin
        n_slots = r_slots;
        n_dist  = r_dist;
        n_str   = r_str;
        n_int   = r_int;
        n_tot   = r_tot;
        n_hdr   = r_hdr;
        n_cks   = r_cks;
        n_frm   = r_frm;
        status  = lfca_pkg::ST_TIMEOUT;
        priority if (i_evt.judge) begin
            if (!hdr_ok) begin
                n_hdr  = r_hdr + 1'b1;
                n_tot  = r_tot + 1'b1;
                status = lfca_pkg::ST_HEADER;
            end else if (!cks_ok) begin
                n_cks  = r_cks + 1'b1;
                n_tot  = r_tot + 1'b1;
                status = lfca_pkg::ST_CHECKSUM;
            end else begin
                n_str                = {i_evt.bytes[5], i_evt.bytes[4]};
                n_int                = i_evt.bytes[6];
                n_slots[i_evt.slot]  = new_dist;
                if (close) begin
                    n_dist = pair_sum[16:1];
                    status = lfca_pkg::ST_ACCEPT;
                end else begin
                    status = lfca_pkg::ST_DISAGREE;
                end
            end
        end else if (i_evt.framing) begin
            n_frm  = r_frm + 1'b1;
            n_tot  = r_tot + 1'b1;
            status = lfca_pkg::ST_FRAMING;
        end else begin
            status = lfca_pkg::ST_TIMEOUT;
        end
    end

    assign o_push = i_evt.judge | i_evt.framing | i_evt.timeout;

    always_comb begin
        o_res.status          = status;
        o_res.distance        = n_dist;
        o_res.strength        = n_str;
        o_res.int_time        = n_int;
        o_res.total_errors    = 32'(n_tot);
        o_res.header_errors   = 32'(n_hdr);
        o_res.checksum_errors = 32'(n_cks);
        o_res.framing_errors  = 32'(n_frm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= lfca_pkg::DELTA_RESET;
            r_slots <= '0;
            r_dist  <= '0;
            r_str   <= '0;
            r_int   <= '0;
            r_tot   <= '0;
            r_hdr   <= '0;
            r_cks   <= '0;
            r_frm   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_delta <= i_cfg_data;
            end
            r_slots <= n_slots;
            r_dist  <= n_dist;
            r_str   <= n_str;
            r_int   <= n_int;
            r_tot   <= n_tot;
            r_hdr   <= n_hdr;
            r_cks   <= n_cks;
            r_frm   <= n_frm;
        end
    end

endmodule

[src/lfca_outq.sv]
// Two-entry result buffer: output register plus skid entry.
// Depends on lfca_pkg.
module lfca_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lfca_pkg::t_out_item i_res,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfca_pkg::t_out_item o_out_data
);

    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    lfca_pkg::t_out_item r_q [2];
    lfca_pkg::t_out_item n_q [2];
    logic                pop;

    assign pop = (r_cnt != 2'd0) && !i_out_stall;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop && i_push) begin
            if (r_cnt == 2'd1) begin
                n_q[0] = i_res;
            end else begin
                n_q[0] = r_q[1];
                n_q[1] = i_res;
            end
        end else if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                n_q[0] = i_res;
            end else begin
                n_q[1] = i_res;
            end
            n_cnt = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[0];

endmodule

[src/lidar_frame_check_and_accept.sv]
// Top level of the range-finder frame checker: input register, assembler, judge, result buffer.
// Depends on lfca_pkg, lfca_assemble, lfca_judge and lfca_outq.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------------
//   input    | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//   output   | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//   config   | i_cfg_we     | none         | i_cfg_data (delta_accept)
//
// One beat per cycle unless stalled: a beat lands in the input register, is judged there
// while the buffer is not full; its result enters a two-entry buffer; o_out_valid rises
// once the buffer holds the result. The input stalls only while a beat waits in the input
// register and both buffer entries are full. Reset is synchronous; it idles the frame
// position, clears slots, reported values and counters, and loads delta_accept with 10.
module lidar_frame_check_and_accept (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lfca_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfca_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data
);

    logic               r_in_valid;
    lfca_pkg::t_in_item r_in_data;
    logic               q_full;
    logic               go;
    lfca_pkg::t_asm_evt evt;
    logic               push;
    lfca_pkg::t_out_item res;

    assign go         = r_in_valid && !q_full;
    assign o_in_stall = r_in_valid && q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // hold the beat while stalled
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    lfca_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in_data),
        .o_evt   (evt)
    );

    lfca_judge u_judge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt),
        .o_push     (push),
        .o_res      (res)
    );

    lfca_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[src/lfca_checker.sv]
// Port-level checker for the range-finder frame block, bound to the top level.
// Depends on lfca_pkg and lidar_frame_check_and_accept_macros.svh.
`include "lidar_frame_check_and_accept_macros.svh"

module lfca_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lfca_pkg::t_out_item o_out_data
);

    `LFCA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result beat changed or vanished")

    `LFCA_ASSERT_ALWAYS(a_reset_idle, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result beat shown right after reset")

    `LFCA_ASSERT(a_stall_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stalled with no result pending")

    `LFCA_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_out_data.status <= lfca_pkg::ST_TIMEOUT), "undefined status code on a result beat")

endmodule

bind lidar_frame_check_and_accept lfca_checker u_lfca_checker (.*);

[verif/testbench.sv]
// Self-checking bench for lidar_frame_check_and_accept: directed table, then random frames.
// Depends on lfca_pkg and the RTL of the block; the frame checker is predicted in-bench.
`timescale 1ns / 100ps

module testbench;
    import lfca_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         DIR_ROWS       = 38;
    localparam int         RAND_PHASES    = 5;
    localparam int         BEATS_PER_PHASE = 150;
    localparam int         LONG_HOLD      = 300;
    localparam int         BURST_BEATS    = 24;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         RUN_LIMIT_NS   = 10_000_000;

    localparam int FR_GOOD    = 0;
    localparam int FR_BAD_SUM = 1;
    localparam int FR_BAD_HDR = 2;
    localparam int FR_CUT     = 3;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = '0;

    // Sideband that travels with each directed beat
    logic        beat_typed = 1'b0;
    t_out_item   typed_want = '0;

    // Frame checker state as the bench sees it
    logic [15:0] delta_model   = DELTA_RESET;
    logic [3:0]  frame_pos     = POS_IDLE;
    logic [7:0]  frame_buf [9];
    logic [15:0] sample_dist [2] = '{16'd0, 16'd0};
    logic [15:0] avg_dist      = '0;
    logic [15:0] last_strength = '0;
    logic [7:0]  last_int_time = '0;
    t_cnt        cnt_total     = '0;
    t_cnt        cnt_header    = '0;
    t_cnt        cnt_checksum  = '0;
    t_cnt        cnt_framing   = '0;

    t_out_item   pending_reports [$];
    int          mismatches = 0;
    int          beats_sent = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          hold_pending = 1'b0;
    bit          holding = 1'b0;
    logic [15:0] base_dist = '0;
    logic [15:0] last_dist = '0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{OP_TIMEOUT, 8'h00, 1'b0, 1'b0}, 1'b1,
          '{ST_TIMEOUT, 16'd0, 16'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
        '{'{OP_UNUSED,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b1}, 1'b0, '0},
        // open a frame, then abort it with a framing error
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h59, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAMING, 8'h00, 1'b0, 1'b0}, 1'b1,
          '{ST_FRAMING, 16'd0, 16'd0, 8'd0, 32'd1, 32'd0, 32'd0, 32'd1}},
        '{'{OP_BYTE,    8'h59, 1'b0, 1'b0}, 1'b0, '0},
        // bad second header byte
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h58, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h01, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h02, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h03, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h04, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h05, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h06, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h07, 1'b0, 1'b0}, 1'b1,
          '{ST_HEADER, 16'd0, 16'd0, 8'd0, 32'd2, 32'd1, 32'd0, 32'd1}},
        // partial frame, dropped by the restart below
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h59, 1'b0, 1'b0}, 1'b0, '0},
        // good frame, all fields at their top values, slot 1
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h59, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'hAD, 1'b0, 1'b1}, 1'b0, '0},
        // timeout with a frame open
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_TIMEOUT, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
        // checksum should be 0xB2
        '{'{OP_BYTE,    8'h59, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h59, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_BYTE,    8'h00, 1'b0, 1'b0}, 1'b1,
          '{ST_CHECKSUM, 16'd0, 16'hFFFF, 8'hFF, 32'd3, 32'd1, 32'd1, 32'd1}}
    };

    lidar_frame_check_and_accept uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Advance the frame checker by one beat; report says whether a result comes out.
    task automatic compute_report(input t_in_item b, output bit report, output t_out_item r);
        logic [2:0]  st;
        logic [7:0]  sum;
        logic [15:0] a;
        logic [15:0] c;
        logic [15:0] diff;
        logic [16:0] pair;
        report = 1'b0;
        st = ST_ACCEPT;
        r = '0;
        case (b.op)
            OP_FRAMING: begin
                frame_pos = POS_IDLE;
                cnt_framing++;
                cnt_total++;
                st = ST_FRAMING;
                report = 1'b1;
            end
            OP_TIMEOUT: begin
                frame_pos = POS_IDLE;
                st = ST_TIMEOUT;
                report = 1'b1;
            end
            OP_BYTE: begin
                if (b.frame_start) begin
                    frame_pos = '0;
                end
                if (frame_pos < POS_IDLE) begin
                    frame_buf[frame_pos] = b.data_byte;
                    if (frame_pos != LAST_POS) begin
                        frame_pos = frame_pos + 4'd1;
                    end else begin
                        frame_pos = POS_IDLE;
                        report = 1'b1;
                        sum = '0;
                        for (int k = 0; k < 8; k++) sum += frame_buf[k];
                        // header is judged before the checksum
                        if (frame_buf[0] != HDR_BYTE || frame_buf[1] != HDR_BYTE) begin
                            cnt_header++;
                            cnt_total++;
                            st = ST_HEADER;
                        end else if (sum != frame_buf[8]) begin
                            cnt_checksum++;
                            cnt_total++;
                            st = ST_CHECKSUM;
                        end else begin
                            last_strength = {frame_buf[5], frame_buf[4]};
                            last_int_time = frame_buf[6];
                            sample_dist[b.slot] = {frame_buf[3], frame_buf[2]};
                            a = sample_dist[0];
                            c = sample_dist[1];
                            diff = (a >= c) ? a - c : c - a;
                            if (diff <= delta_model) begin
                                pair = {1'b0, a} + {1'b0, c};
                                avg_dist = pair[16:1];
                                st = ST_ACCEPT;
                            end else begin
                                st = ST_DISAGREE;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (report) begin
            r = '{st, avg_dist, last_strength, last_int_time,
                  cnt_total, cnt_header, cnt_checksum, cnt_framing};
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_report(input t_out_item want, input t_out_item got);
        check_field("status", want.status, got.status);
        check_field("distance", want.distance, got.distance);
        check_field("strength", want.strength, got.strength);
        check_field("int_time", want.int_time, got.int_time);
        check_field("total_errors", want.total_errors, got.total_errors);
        check_field("header_errors", want.header_errors, got.header_errors);
        check_field("checksum_errors", want.checksum_errors, got.checksum_errors);
        check_field("framing_errors", want.framing_errors, got.framing_errors);
    endtask

    // Both channels are sampled here, before any bench or block update of this edge lands
    always @(posedge i_clk) begin
        t_out_item guess;
        bit        report;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            compute_report(i_in_data, report, guess);
            if (report) begin
                pending_reports.push_back(beat_typed ? typed_want : guess);
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual status %0h",
                         $time, o_out_data.status);
                mismatches++;
            end else begin
                check_report(pending_reports.pop_front(), o_out_data);
            end
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_beat(input t_in_item it, input logic typed = 1'b0,
                             input t_out_item want = '0);
        int gap;
        gap = pick_gap(tx_calm);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        beat_typed <= typed;
        typed_want <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_frame(input int kind);
        logic [7:0]  fb [9];
        logic [7:0]  sum;
        logic [15:0] frame_dist;
        t_in_item    it;
        int          len;
        case ($urandom_range(0, 5))
            0:       frame_dist = 16'($urandom);
            1:       frame_dist = last_dist;
            default: frame_dist = base_dist + 16'($urandom_range(0, 24));
        endcase
        last_dist = frame_dist;
        fb[0] = HDR_BYTE;
        fb[1] = HDR_BYTE;
        fb[2] = frame_dist[7:0];
        fb[3] = frame_dist[15:8];
        for (int k = 4; k < 8; k++) fb[k] = 8'($urandom);
        sum = '0;
        for (int k = 0; k < 8; k++) sum += fb[k];
        fb[8] = sum;
        len = 9;
        case (kind)
            FR_BAD_SUM: fb[8] = sum ^ 8'($urandom_range(1, 255));
            FR_BAD_HDR: fb[$urandom_range(0, 1)] = HDR_BYTE ^ 8'($urandom_range(1, 255));
            FR_CUT:     len = $urandom_range(1, 8);
            default: ;
        endcase
        for (int k = 0; k < len; k++) begin
            it.op          = OP_BYTE;
            it.data_byte   = fb[k];
            it.frame_start = (k == 0);
            it.slot        = 1'($urandom);
            send_beat(it);
        end
    endtask

    // Drop valid and hold until every result is back, then idle for DRAIN_CYCLES so ignored beats settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delta(input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        delta_model = v;
        i_cfg_we   <= 1'b0;
    endtask

    // Result side: random stall runs, one long hold on request
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                holding = 1'b1;
                hold = LONG_HOLD;
            end else begin
                hold = pick_gap(rx_calm);
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                holding = 1'b0;
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    end

    initial begin
        t_in_item    it;
        logic [15:0] new_delta;
        int          pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       new_delta = 16'd0;
                1:       new_delta = 16'hFFFF;
                2:       new_delta = DELTA_RESET;
                3:       new_delta = 16'($urandom_range(1, 40));
                default: new_delta = 16'($urandom);
            endcase
            write_delta(new_delta);
            base_dist = (ph == 1) ? 16'hFFF0 : 16'($urandom);

            if (ph == 2) begin
                // back up the result buffer so the input has to stall
                hold_pending = 1'b1;
                wait (holding);
                tx_calm = 1'b1;
                repeat (BURST_BEATS) begin
                    it.op          = ($urandom_range(0, 1) != 0) ? OP_TIMEOUT : OP_FRAMING;
                    it.data_byte   = 8'($urandom);
                    it.frame_start = 1'($urandom);
                    it.slot        = 1'($urandom);
                    send_beat(it);
                end
            end

            while (beats_sent < DIR_ROWS + (ph + 1) * BEATS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 66) begin
                    send_frame(FR_GOOD);
                end else if (pick < 74) begin
                    send_frame(FR_BAD_SUM);
                end else if (pick < 81) begin
                    send_frame(FR_BAD_HDR);
                end else if (pick < 89) begin
                    send_frame(FR_CUT);
                end else begin
                    it.op          = 2'($urandom);
                    it.data_byte   = 8'($urandom);
                    it.frame_start = ($urandom_range(0, 3) == 0);
                    it.slot        = 1'($urandom);
                    send_beat(it);
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule
